// ===== design/word_initial_sequence_matcher_assert.svh =====
// Assertion macros shared by the matcher modules.
`ifndef WORD_INITIAL_SEQUENCE_MATCHER_ASSERT_SVH
`define WORD_INITIAL_SEQUENCE_MATCHER_ASSERT_SVH

// Implication checked in the same cycle, sampled on clk, off during reset.
`define WISM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matcher check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define WISM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matcher check failed");

`endif

// ===== design/wism_pkg.sv =====
// Package: constants, types and character helpers of the word-initial matcher.
`timescale 1ns / 1ps
package wism_pkg;

  localparam int POSITION_BITS = 24;
  localparam int MAX_PATTERN   = 8;
  localparam int PATTERN_BITS  = 64;
  localparam int LENGTH_BITS   = 4;
  localparam int IDX_BITS      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_BYTES  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LENGTH = CFG_IDX_BITS'(1);

  localparam logic [LENGTH_BITS-1:0] PATTERN_LENGTH_RESET = LENGTH_BITS'(1);

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_LESS     = 8'h3C;
  localparam logic [7:0] CH_GREATER  = 8'h3E;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic [PATTERN_BITS-1:0] pattern_bytes;
    logic [LENGTH_BITS-1:0]  used_length;
  } cfg_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] match_start;
    logic [POSITION_BITS-1:0] match_length;
    logic                     position_saturated;
  } res_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_skip(input logic [7:0] c);
    return (c == CH_DOT) || (c == CH_COMMA) || (c == CH_LESS) ||
           (c == CH_GREATER) || (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c + CASE_OFFSET) : c;
  endfunction

  // Out-of-range lengths: zero counts as one, anything above the maximum as the maximum.
  function automatic logic [LENGTH_BITS-1:0] used_length(input logic [LENGTH_BITS-1:0] n);
    logic [LENGTH_BITS-1:0] r;
    if (n == '0) begin
      r = LENGTH_BITS'(1);
    end else if (n > LENGTH_BITS'(MAX_PATTERN)) begin
      r = LENGTH_BITS'(MAX_PATTERN);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

// ===== design/wism_in_if.sv =====
// Interface: text byte channel of the matcher.
`timescale 1ns / 1ps
interface wism_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// ===== design/wism_out_if.sv =====
// Interface: match result channel of the matcher.
`timescale 1ns / 1ps
interface wism_out_if;
  logic                              valid;
  logic                              ready;
  logic [wism_pkg::POSITION_BITS-1:0] match_start;
  logic [wism_pkg::POSITION_BITS-1:0] match_length;
  logic                              position_saturated;

  modport source (output valid, output match_start, output match_length,
                  output position_saturated, input ready);
  modport sink   (input valid, input match_start, input match_length,
                  input position_saturated, output ready);
endinterface

// ===== design/wism_scan.sv =====
// Scan state and per-byte update of the word-initial matcher.
`timescale 1ns / 1ps
`include "word_initial_sequence_matcher_assert.svh"
module wism_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [7:0]                         text_byte,
  input  logic                               last_byte,
  input  wism_pkg::cfg_t                     cfg,
  output logic                               res_valid,
  output wism_pkg::res_t                     res
);
  import wism_pkg::*;

  localparam int WIDE_BITS = POSITION_BITS + 1;

  logic                     after_space_r, after_space_nxt;
  logic                     inside_brackets_r, inside_brackets_nxt;
  logic [IDX_BITS-1:0]      pattern_index_r, pattern_index_nxt;
  logic                     start_known_r, start_known_nxt;
  logic [POSITION_BITS-1:0] start_position_r, start_position_nxt;
  logic [POSITION_BITS-1:0] byte_position_r, byte_position_nxt;
  logic                     end_pending_r, end_pending_nxt;
  logic [POSITION_BITS-1:0] pending_start_r, pending_start_nxt;

  logic                     sat;
  logic [7:0]               want;
  logic [POSITION_BITS-1:0] run_start;
  logic [WIDE_BITS-1:0]     end_wide;
  logic [WIDE_BITS-1:0]     len_wide;

  always_comb begin
    sat       = &byte_position_r;
    want      = cfg.pattern_bytes[pattern_index_r * 8 +: 8];
    run_start = start_known_r ? start_position_r : byte_position_r;

    after_space_nxt     = after_space_r;
    inside_brackets_nxt = inside_brackets_r;
    pattern_index_nxt   = pattern_index_r;
    start_known_nxt     = start_known_r;
    start_position_nxt  = start_position_r;
    byte_position_nxt   = byte_position_r;
    end_pending_nxt     = end_pending_r;
    pending_start_nxt   = pending_start_r;
    res_valid           = 1'b0;
    end_wide            = {1'b0, byte_position_r};

    priority if (is_white(text_byte)) begin
      after_space_nxt = 1'b1;
      if (end_pending_r) begin
        end_pending_nxt = 1'b0;
        res_valid       = step;
      end
    end else if ((text_byte == CH_LPAREN) || (text_byte == CH_RPAREN)) begin
      inside_brackets_nxt = !inside_brackets_r;
    end else if (after_space_r && !inside_brackets_r) begin
      after_space_nxt = 1'b0;
      if (!is_skip(text_byte)) begin
        if (to_lower(text_byte) == want) begin
          start_known_nxt    = 1'b1;
          start_position_nxt = run_start;
          if ((LENGTH_BITS'(pattern_index_r) + LENGTH_BITS'(1)) >= cfg.used_length) begin
            pending_start_nxt = run_start;
            end_pending_nxt   = 1'b1;
            pattern_index_nxt = '0;
            start_known_nxt   = 1'b0;
          end else begin
            pattern_index_nxt = pattern_index_r + IDX_BITS'(1);
          end
        end else begin
          pattern_index_nxt = '0;
          start_known_nxt   = 1'b0;
        end
      end
    end else begin
      after_space_nxt = after_space_r;
    end

    // A run still open at the end of the text closes on the final byte itself.
    if (last_byte && end_pending_nxt) begin
      end_pending_nxt = 1'b0;
      end_wide        = {1'b0, byte_position_r} + WIDE_BITS'(1);
      res_valid       = step;
    end

    len_wide                 = end_wide - {1'b0, pending_start_nxt};
    res.match_start          = pending_start_nxt;
    res.match_length         = len_wide[POSITION_BITS] ? '1 : len_wide[POSITION_BITS-1:0];
    res.position_saturated   = sat;

    if (last_byte) begin
      after_space_nxt     = 1'b1;
      inside_brackets_nxt = 1'b0;
      pattern_index_nxt   = '0;
      start_known_nxt     = 1'b0;
      start_position_nxt  = '0;
      byte_position_nxt   = '0;
      end_pending_nxt     = 1'b0;
      pending_start_nxt   = '0;
    end else if (!sat) begin
      byte_position_nxt = byte_position_r + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_space_r     <= 1'b1;
      inside_brackets_r <= 1'b0;
      pattern_index_r   <= '0;
      start_known_r     <= 1'b0;
      start_position_r  <= '0;
      byte_position_r   <= '0;
      end_pending_r     <= 1'b0;
      pending_start_r   <= '0;
    end else if (step) begin
      after_space_r     <= after_space_nxt;
      inside_brackets_r <= inside_brackets_nxt;
      pattern_index_r   <= pattern_index_nxt;
      start_known_r     <= start_known_nxt;
      start_position_r  <= start_position_nxt;
      byte_position_r   <= byte_position_nxt;
      end_pending_r     <= end_pending_nxt;
      pending_start_r   <= pending_start_nxt;
    end
  end

  `WISM_ASSERT_NOW(a_pending_not_ahead, end_pending_r, pending_start_r <= byte_position_r)
  `WISM_ASSERT_NOW(a_start_not_ahead, start_known_r, start_position_r <= byte_position_r)
  `WISM_ASSERT_NOW(a_result_needs_step, res_valid, step)

endmodule

// ===== design/word_initial_sequence_matcher.sv =====
// Top level of the word-initial sequence matcher: input stage, scan, result buffer.
// A taken text beat is held in the input register; its result goes to the output or skid register.
// Throughput: one text beat per cycle while out_ch keeps up; behind a stalled result beat
//   in_ch takes no new beat while one is in the input register and closes once the skid is full.
// Reset: rst_n is synchronous and active low; it clears the scan state and buffers and
//   sets pattern_bytes to zero and pattern_length to one.
`timescale 1ns / 1ps
`include "word_initial_sequence_matcher_assert.svh"
module word_initial_sequence_matcher (
  input  logic                                clk,
  input  logic                                rst_n,
  wism_in_if.sink                             in_ch,
  wism_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [wism_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wism_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import wism_pkg::*;

  // Configuration registers. They must be written only while the block is idle, so the scan
  // sees a steady pattern for the whole of a text; the block itself does not enforce this.
  logic [PATTERN_BITS-1:0] pattern_bytes_r;
  logic [LENGTH_BITS-1:0]  pattern_length_r;
  cfg_t                    cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      pattern_length_r <= PATTERN_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:  pattern_bytes_r  <= cfg_wdata[PATTERN_BITS-1:0];
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[LENGTH_BITS-1:0];
        default:            pattern_bytes_r  <= pattern_bytes_r;
      endcase
    end
  end

  assign cfg.pattern_bytes = pattern_bytes_r;
  assign cfg.used_length   = used_length(pattern_length_r);

  // Input register: every accepted beat is held here while the scan consumes it.
  logic       s1_valid_r;
  logic [7:0] s1_text_r;
  logic       s1_last_r;
  logic       accept;

  // Result buffer: the output register carries the beat shown on out_ch, the skid
  // register catches a result that arrives while that beat is stalled.
  logic   out_valid_r, out_valid_nxt;
  res_t   out_data_r, out_data_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  res_t   skid_data_r, skid_data_nxt;
  logic   out_taken;

  logic   scan_valid;
  res_t   scan_res;

  // The input is taken only when the beat now in the input register cannot fill the
  // skid; then the next beat is sure to find a free slot when it is scanned.
  assign in_ch.ready = !skid_valid_r && !(s1_valid_r && out_valid_r && !out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_text_r <= in_ch.text_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  wism_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_valid_r),
    .text_byte (s1_text_r),
    .last_byte (s1_last_r),
    .cfg       (cfg),
    .res_valid (scan_valid),
    .res       (scan_res)
  );

  assign out_taken = out_valid_r && out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_taken) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_taken) begin
      out_valid_nxt = scan_valid;
      out_data_nxt  = scan_res;
    end else if (scan_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = scan_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.match_start        = out_data_r.match_start;
  assign out_ch.match_length       = out_data_r.match_length;
  assign out_ch.position_saturated = out_data_r.position_saturated;

  // The skid only ever fills behind a stalled output beat.
  `WISM_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  // A beat being scanned always finds the skid free.
  `WISM_ASSERT_NOW(a_scan_has_room, s1_valid_r, !skid_valid_r)
  // A full buffer closes the input.
  `WISM_ASSERT_NOW(a_full_blocks_input, skid_valid_r, !in_ch.ready)

endmodule
